// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/orb_pkg.sv =====
// Package with the command codes, fixed field widths and shared types of the ring buffer.
package orb_pkg;

   localparam int CMD_W  = 2;
   localparam int DATA_W = 64;
   localparam int SLOT_W = 6;
   localparam int SIZE_W = 7;

   localparam logic [CMD_W-1:0] CMD_PUSH       = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PULL       = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK_NEWER = 2'd2;
   localparam logic [CMD_W-1:0] CMD_PEEK_OLDER = 2'd3;

   localparam int RESET_SLOTS = 64;
   localparam int SIZE_LIMIT  = 127;

   typedef struct packed {
      logic              ok;
      logic              overwrote;
      logic              uses_read;
      logic [SLOT_W-1:0] slot;
      logic [SIZE_W-1:0] fill;
   } rsp_meta_type;

endpackage

// ===== sv/orb_req_if.sv =====
// Interface of the request channel: valid, ready and the request fields.
interface orb_req_if;
   import orb_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [DATA_W-1:0] data_in;
   logic              cursor_given;
   logic [SLOT_W-1:0] cursor_slot;

   modport source (output valid, cmd, data_in, cursor_given, cursor_slot, input ready);
   modport sink (input valid, cmd, data_in, cursor_given, cursor_slot, output ready);
endinterface

// ===== sv/orb_rsp_if.sv =====
// Interface of the response channel: valid, ready and the response fields.
interface orb_rsp_if;
   import orb_pkg::*;

   logic              valid;
   logic              ready;
   logic              ok;
   logic              overwrote;
   logic [DATA_W-1:0] data_out;
   logic [SLOT_W-1:0] slot_out;
   logic [SIZE_W-1:0] fill_level;

   modport source (output valid, ok, overwrote, data_out, slot_out, fill_level, input ready);
   modport sink (input valid, ok, overwrote, data_out, slot_out, fill_level, output ready);
endinterface

// ===== sv/orb_ram.sv =====
// Generic single-port RAM with a registered read.
module orb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/orb_ctrl.sv =====
// Pointer, fill count and ring size registers with the per-transaction command decode.
module orb_ctrl import orb_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [SIZE_W-1:0]     csr_wr_data,
   input  logic                  accept,
   input  logic [CMD_W-1:0]      cmd,
   input  logic                  cursor_given,
   input  logic [SLOT_W-1:0]     cursor_slot,
   output logic                  ram_wr_en,
   output logic                  ram_rd_en,
   output logic [$clog2((DEPTH < SIZE_LIMIT) ? DEPTH : SIZE_LIMIT)-1:0] ram_addr,
   output rsp_meta_type          meta
);

   localparam int MAX_SIZE   = (DEPTH < SIZE_LIMIT) ? DEPTH : SIZE_LIMIT;
   localparam int PTR_W      = $clog2(MAX_SIZE);
   localparam int CNT_W      = $clog2(MAX_SIZE + 1);
   localparam int RESET_SIZE = (RESET_SLOTS < MAX_SIZE) ? RESET_SLOTS : MAX_SIZE;

   function automatic logic [PTR_W-1:0] step_fwd(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] sz);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(p) + CNT_W'(1);
      return (nxt >= sz) ? '0 : PTR_W'(nxt);
   endfunction

   function automatic logic [PTR_W-1:0] step_back(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] sz);
      return (p == '0) ? PTR_W'(sz - CNT_W'(1)) : p - PTR_W'(1);
   endfunction

   logic [CNT_W-1:0] size_ff, size_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] cursor;
   logic [PTR_W-1:0] peek_ptr;
   logic             full;
   logic             empty;

   // Out-of-range sizes are clamped once, when the register is written.
   always_comb begin
      size_in = size_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            size_in = CNT_W'(1);
         end else if (csr_wr_data > SIZE_W'(MAX_SIZE)) begin
            size_in = CNT_W'(MAX_SIZE);
         end else begin
            size_in = CNT_W'(csr_wr_data);
         end
      end
   end

   always_comb begin
      if ({1'b0, cursor_slot} >= SIZE_W'(size_ff)) begin
         cursor = PTR_W'(size_ff - CNT_W'(1));
      end else begin
         cursor = PTR_W'(cursor_slot);
      end
   end

   assign full  = (count_ff == size_ff);
   assign empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      ram_addr  = rd_ptr_ff;
      peek_ptr  = rd_ptr_ff;
      meta      = '0;

      if (cmd == CMD_PEEK_NEWER) begin
         peek_ptr = step_back(cursor_given ? cursor : wr_ptr_ff, size_ff);
      end else if (cursor_given) begin
         peek_ptr = step_fwd(cursor, size_ff);
      end

      unique case (cmd) inside
         CMD_PUSH: begin
            ram_wr_en      = accept;
            ram_addr       = wr_ptr_ff;
            wr_ptr_in      = step_fwd(wr_ptr_ff, size_ff);
            meta.ok        = 1'b1;
            meta.overwrote = full;
            if (full) begin
               rd_ptr_in = step_fwd(rd_ptr_ff, size_ff);
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_PULL: begin
            if (!empty) begin
               ram_rd_en      = accept;
               ram_addr       = rd_ptr_ff;
               rd_ptr_in      = step_fwd(rd_ptr_ff, size_ff);
               count_in       = count_ff - CNT_W'(1);
               meta.ok        = 1'b1;
               meta.uses_read = 1'b1;
            end
         end
         CMD_PEEK_NEWER, CMD_PEEK_OLDER: begin
            if (!empty) begin
               ram_rd_en      = accept;
               ram_addr       = peek_ptr;
               meta.ok        = 1'b1;
               meta.uses_read = 1'b1;
               meta.slot      = SLOT_W'(peek_ptr);
            end
         end
         default: begin
            meta.ok = 1'b0;
         end
      endcase

      meta.fill = SIZE_W'(count_in);
   end

   // A size write empties the ring; the stored words are left in place.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= CNT_W'(RESET_SIZE);
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else if (csr_wr_en) begin
         size_ff   <= size_in;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/overwrite_ring_buffer_core.sv =====
// Top level of the ring buffer with overwrite: control, slot memory and response register.
//
// The ring buffer accepts one transaction per clock cycle while the response channel does
// not stall, and returns exactly one response for each, in order: the pointer update and
// the registered read of the single-port slot memory come first, then the response register.
// The slot memory holds min(DEPTH, 127) words of WORD_WIDTH bits; a pushed word is
// truncated to WORD_WIDTH bits and returned zero-extended. A push on a full ring
// replaces the oldest entry and moves the read pointer past it. Writing the size
// register empties the ring at once, so it should only be written while no transaction
// is in flight. Reading a slot that was never written returns an undefined word.
module overwrite_ring_buffer_core import orb_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int WORD_WIDTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   orb_req_if.sink           req_chan,
   orb_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   localparam int MAX_SIZE = (DEPTH < SIZE_LIMIT) ? DEPTH : SIZE_LIMIT;
   localparam int PTR_W    = $clog2(MAX_SIZE);

   logic                  accept;
   logic                  rsp_load;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [PTR_W-1:0]      ram_addr;
   logic [WORD_WIDTH-1:0] ram_rd_data;
   rsp_meta_type          meta;

   logic                  s1_valid_ff, s1_valid_in;
   rsp_meta_type          s1_meta_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_meta_type          rsp_meta_ff;
   logic [DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   assign rsp_load       = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || rsp_load;
   assign accept         = req_chan.valid && req_chan.ready;

   orb_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .accept       (accept),
      .cmd          (req_chan.cmd),
      .cursor_given (req_chan.cursor_given),
      .cursor_slot  (req_chan.cursor_slot),
      .ram_wr_en    (ram_wr_en),
      .ram_rd_en    (ram_rd_en),
      .ram_addr     (ram_addr),
      .meta         (meta)
   );

   orb_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (MAX_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (req_chan.data_in[WORD_WIDTH-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (rsp_load) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in = s1_meta_ff.uses_read ? DATA_W'(ram_rd_data) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
      end
      if (rsp_load) begin
         rsp_meta_ff <= s1_meta_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ok         = rsp_meta_ff.ok;
   assign rsp_chan.overwrote  = rsp_meta_ff.overwrote;
   assign rsp_chan.data_out   = rsp_data_ff;
   assign rsp_chan.slot_out   = rsp_meta_ff.slot;
   assign rsp_chan.fill_level = rsp_meta_ff.fill;

endmodule

// ===== sv/orb_checker.sv =====
// Checker on the ports of the ring buffer, with the bind that attaches it to the top level.
`include "assert_macros.svh"

module orb_checker import orb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_ok,
   input logic              rsp_overwrote,
   input logic [DATA_W-1:0] rsp_data_out,
   input logic [SLOT_W-1:0] rsp_slot_out,
   input logic [SIZE_W-1:0] rsp_fill_level
);

   // A failed pull or peek carries no word, no slot and no overwrite flag.
   `ASSERT_IMPLIES(a_fail_is_clean, clock, reset, rsp_valid && !rsp_ok, rsp_data_out == '0 && rsp_slot_out == '0 && !rsp_overwrote)

   // An overwrite only happens on a successful push into a non-empty ring.
   `ASSERT_IMPLIES(a_overwrite_full, clock, reset, rsp_valid && rsp_overwrote, rsp_ok && rsp_fill_level != '0 && rsp_data_out == '0)

   // Reset leaves no transaction pending on the response side.
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

   // A stalled response keeps its contents.
   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_out) && $stable(rsp_fill_level))

endmodule

bind overwrite_ring_buffer_core orb_checker u_orb_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_ok         (rsp_chan.ok),
   .rsp_overwrote  (rsp_chan.overwrote),
   .rsp_data_out   (rsp_chan.data_out),
   .rsp_slot_out   (rsp_chan.slot_out),
   .rsp_fill_level (rsp_chan.fill_level)
);

// ===== tb/sv/tb_overwrite_ring_buffer_core.sv =====
// Self-checking testbench of the ring buffer with overwrite, with a predictor and scoreboard.
`timescale 1ns / 1ps

module tb_overwrite_ring_buffer_core;
   import orb_pkg::*;

   localparam int RING_DEPTH  = 64;
   localparam int CYCLE_LIMIT = 100000;
   localparam int STIM_COPY   = 0;
   localparam int SCORE_COPY  = 1;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] data;
      logic              given;
      logic [SLOT_W-1:0] cursor;
   } ring_req_type;

   typedef struct packed {
      logic              ok;
      logic              overwrote;
      logic [DATA_W-1:0] data;
      logic [SLOT_W-1:0] slot;
      logic [SIZE_W-1:0] fill;
   } ring_rsp_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;

   orb_req_if req_chan ();
   orb_rsp_if rsp_chan ();

   overwrite_ring_buffer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Two copies of the ring state: one steers the stimulus, one scores the responses.
   bit [DATA_W-1:0]   ring_word    [2][RING_DEPTH];
   bit                ring_written [2][RING_DEPTH];
   int unsigned       ring_wp      [2];
   int unsigned       ring_rp      [2];
   int unsigned       ring_count   [2];
   logic [SIZE_W-1:0] ring_size_reg[2];

   ring_req_type req_pending_q[$];
   ring_rsp_type rsp_due_q[$];
   ring_req_type next_req;
   ring_rsp_type due_rsp;
   ring_rsp_type scored_rsp;
   logic [SLOT_W-1:0] walk_slot;
   bit req_taken;
   bit no_idle;
   bit hold_request;
   bit rsp_hold;
   int mismatch_count;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned ring_span(input int c);
      int unsigned s;
      s = 32'(ring_size_reg[c]);
      if (s < 1) s = 1;
      if (s > RING_DEPTH) s = RING_DEPTH;
      return s;
   endfunction

   function automatic int unsigned ring_fwd(input int unsigned p, input int unsigned size);
      return (p + 1 >= size) ? 0 : p + 1;
   endfunction

   function automatic int unsigned ring_back(input int unsigned p, input int unsigned size);
      return (p == 0) ? size - 1 : p - 1;
   endfunction

   function automatic void ring_configure(input int c, input logic [SIZE_W-1:0] value);
      ring_size_reg[c] = value;
      ring_wp[c] = 0;
      ring_rp[c] = 0;
      ring_count[c] = 0;
   endfunction

   // Applies one transaction to a copy of the ring; returns 0 if it read a slot never written.
   function automatic bit ring_access(input int c, input ring_req_type req,
                                      output ring_rsp_type rsp);
      int unsigned size;
      int unsigned cursor;
      int unsigned p;
      bit clean;
      size = ring_span(c);
      cursor = 32'(req.cursor);
      clean = 1'b1;
      rsp = '0;
      if (cursor >= size) cursor = size - 1;
      if (ring_wp[c] >= size) ring_wp[c] = 0;
      if (ring_rp[c] >= size) ring_rp[c] = 0;
      if (ring_count[c] > size) ring_count[c] = size;
      if (req.cmd == CMD_PUSH) begin
         ring_word[c][ring_wp[c]] = req.data;
         ring_written[c][ring_wp[c]] = 1'b1;
         ring_wp[c] = ring_fwd(ring_wp[c], size);
         if (ring_count[c] >= size) begin
            ring_rp[c] = ring_fwd(ring_rp[c], size);
            rsp.overwrote = 1'b1;
         end else begin
            ring_count[c] = ring_count[c] + 1;
         end
         rsp.ok = 1'b1;
      end else if (ring_count[c] != 0) begin
         rsp.ok = 1'b1;
         if (req.cmd == CMD_PULL) begin
            p = ring_rp[c];
            ring_rp[c] = ring_fwd(ring_rp[c], size);
            ring_count[c] = ring_count[c] - 1;
         end else begin
            if (req.cmd == CMD_PEEK_NEWER) begin
               p = ring_back(req.given ? cursor : ring_wp[c], size);
            end else begin
               p = req.given ? ring_fwd(cursor, size) : ring_rp[c];
            end
            rsp.slot = p[SLOT_W-1:0];
         end
         rsp.data = ring_word[c][p];
         clean = ring_written[c][p];
      end
      rsp.fill = ring_count[c][SIZE_W-1:0];
      return clean;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] expected,
                                  input logic [DATA_W-1:0] got);
      mismatch_count++;
      $display("mismatch in %s at cycle %0d: expected %h, got %h",
               what, cycle_count, expected, got);
   endtask

   // A peek whose cursor would land on a slot never written falls back to the current end.
   task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data,
                             input bit given, input logic [SLOT_W-1:0] cursor);
      ring_req_type r;
      ring_rsp_type planned;
      r.cmd = cmd;
      r.data = data;
      r.given = given;
      r.cursor = cursor;
      if (!ring_access(STIM_COPY, r, planned)) begin
         r.given = 1'b0;
         void'(ring_access(STIM_COPY, r, planned));
      end
      if (planned.ok && (cmd == CMD_PEEK_NEWER || cmd == CMD_PEEK_OLDER))
         walk_slot = planned.slot;
      req_pending_q.push_back(r);
   endtask

   task automatic queue_random(input int push_pct);
      int roll;
      logic [CMD_W-1:0] cmd;
      logic [DATA_W-1:0] data;
      logic [SLOT_W-1:0] cursor;
      roll = $urandom_range(99);
      if (roll < push_pct) cmd = CMD_PUSH;
      else if (roll < push_pct + (100 - push_pct) / 3) cmd = CMD_PULL;
      else cmd = $urandom_range(1) ? CMD_PEEK_NEWER : CMD_PEEK_OLDER;
      data = {$urandom, $urandom};
      case ($urandom_range(15))
         0: data = '1;
         1: data = '0;
         default: ;
      endcase
      cursor = ($urandom_range(3) == 0) ? SLOT_W'($urandom) : walk_slot;
      queue_item(cmd, data, $urandom_range(99) < 70, cursor);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (req_pending_q.size() != 0 || req_chan.valid || rsp_due_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_ring_size(input logic [SIZE_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      ring_configure(STIM_COPY, value);
      ring_configure(SCORE_COPY, value);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (req_pending_q.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
            next_req = req_pending_q.pop_front();
            req_chan.cmd <= next_req.cmd;
            req_chan.data_in <= next_req.data;
            req_chan.cursor_given <= next_req.given;
            req_chan.cursor_slot <= next_req.cursor;
            req_chan.valid <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !reset && !rsp_hold && (no_idle || $urandom_range(99) >= 30);
   end

   initial begin
      rsp_hold = 1'b0;
      wait (hold_request);
      rsp_hold <= 1'b1;
      repeat (300) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rsp_due_q.size() == 0) begin
            report_mismatch("unexpected response", '0, rsp_chan.data_out);
         end else begin
            due_rsp = rsp_due_q.pop_front();
            if (rsp_chan.ok !== due_rsp.ok)
               report_mismatch("ok", DATA_W'(due_rsp.ok), DATA_W'(rsp_chan.ok));
            if (rsp_chan.overwrote !== due_rsp.overwrote)
               report_mismatch("overwrote", DATA_W'(due_rsp.overwrote),
                               DATA_W'(rsp_chan.overwrote));
            if (rsp_chan.data_out !== due_rsp.data)
               report_mismatch("data_out", due_rsp.data, rsp_chan.data_out);
            if (rsp_chan.slot_out !== due_rsp.slot)
               report_mismatch("slot_out", DATA_W'(due_rsp.slot), DATA_W'(rsp_chan.slot_out));
            if (rsp_chan.fill_level !== due_rsp.fill)
               report_mismatch("fill_level", DATA_W'(due_rsp.fill),
                               DATA_W'(rsp_chan.fill_level));
         end
      end
      if (!reset && req_chan.valid && req_chan.ready) begin
         next_req.cmd = req_chan.cmd;
         next_req.data = req_chan.data_in;
         next_req.given = req_chan.cursor_given;
         next_req.cursor = req_chan.cursor_slot;
         void'(ring_access(SCORE_COPY, next_req, scored_rsp));
         rsp_due_q.push_back(scored_rsp);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      int phase_size[10];
      int push_pct;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.cmd = CMD_PUSH;
      req_chan.data_in = '0;
      req_chan.cursor_given = 1'b0;
      req_chan.cursor_slot = '0;
      rsp_chan.ready = 1'b0;
      req_taken = 1'b0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      mismatch_count = 0;
      walk_slot = '0;
      ring_size_reg[STIM_COPY] = SIZE_W'(RESET_SLOTS);
      ring_size_reg[SCORE_COPY] = SIZE_W'(RESET_SLOTS);
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_ring_size(SIZE_W'(3));
      queue_item(CMD_PULL, '1, 1'b1, 6'd63);
      queue_item(CMD_PEEK_NEWER, '0, 1'b0, 6'd0);
      queue_item(CMD_PEEK_OLDER, '0, 1'b1, 6'd63);
      queue_item(CMD_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd0);
      queue_item(CMD_PUSH, 64'h0, 1'b1, 6'd63);
      queue_item(CMD_PUSH, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 6'd0);
      queue_item(CMD_PUSH, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 6'd0);
      queue_item(CMD_PUSH, 64'h0123_4567_89AB_CDEF, 1'b0, 6'd0);
      queue_item(CMD_PEEK_NEWER, '0, 1'b0, 6'd0);
      queue_item(CMD_PEEK_NEWER, '0, 1'b1, 6'd0);
      queue_item(CMD_PEEK_NEWER, '0, 1'b1, 6'd63);
      queue_item(CMD_PEEK_OLDER, '0, 1'b0, 6'd0);
      queue_item(CMD_PEEK_OLDER, '0, 1'b1, 6'd2);
      queue_item(CMD_PEEK_OLDER, '0, 1'b1, 6'd63);
      queue_item(CMD_PULL, '0, 1'b0, 6'd0);
      queue_item(CMD_PULL, '0, 1'b0, 6'd0);
      queue_item(CMD_PULL, '0, 1'b0, 6'd0);
      queue_item(CMD_PULL, '0, 1'b0, 6'd0);
      queue_item(CMD_PEEK_OLDER, '0, 1'b0, 6'd0);
      wait_drained();

      phase_size = '{0, 1, 2, 127, 64, 7, 100, 0, 0, 64};
      phase_size[7] = $urandom_range(3, 63);
      phase_size[8] = $urandom_range(3, 63);
      for (int ph = 0; ph < 10; ph++) begin
         write_ring_size(SIZE_W'(phase_size[ph]));
         no_idle <= (ph == 4);
         push_pct = $urandom_range(25, 70);
         if (ph == 9) begin
            hold_request <= 1'b1;
            push_pct = 80;
         end
         for (int n = 0; n < 125; n++) queue_random(push_pct);
         wait_drained();
      end
      no_idle <= 1'b0;
      repeat (10) @(negedge clock);

      if (mismatch_count == 0 && rsp_due_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== overwrite_ring_buffer_core.f =====
+incdir+sv
sv/orb_pkg.sv
sv/orb_req_if.sv
sv/orb_rsp_if.sv
sv/orb_ram.sv
sv/orb_ctrl.sv
sv/overwrite_ring_buffer_core.sv
sv/orb_checker.sv
tb/sv/tb_overwrite_ring_buffer_core.sv
